// ===== design/dmc_pkg.sv =====
// Shared types and constants for the direct-mapped cache.
package dmc_pkg;

	localparam int LINES        = 8;
	localparam int LINE_BYTES   = 16;
	localparam int MEMORY_BYTES = 4096;
	localparam int ADDR_W       = 12;
	localparam int WORD_W       = $clog2(LINE_BYTES);
	localparam int LINE_W       = $clog2(LINES);
	localparam int TAG_W        = ADDR_W - WORD_W - LINE_W;
	localparam int MEM_AW       = $clog2(MEMORY_BYTES);
	localparam int LINE_MEM_AW  = LINE_W + WORD_W;
	localparam int QPTR_W       = 1;
	localparam int QUEUE_DEPTH  = 2 ** QPTR_W;

	localparam logic [7:0] PENALTY_RESET = 8'd20;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_ACCESS = 1'b1
	} op_t;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] address;
		logic [7:0]        load_byte;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [7:0]  read_byte;
		logic [15:0] miss_total;
		logic [31:0] elapsed_time;
	} rsp_t;

	typedef struct packed {
		op_t               op;
		logic [TAG_W-1:0]  tag;
		logic [LINE_W-1:0] line;
		logic [WORD_W-1:0] word;
		logic [MEM_AW-1:0] mem_addr;
		logic [7:0]        load_byte;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_FILL,
		BK_READ,
		BK_RESP
	} bk_state_t;

endpackage

// ===== design/dmc_front.sv =====
// Front end: input handshake and address decode into queue commands.
module dmc_front (
	input  logic          req_valid,
	output logic          req_ready,
	input  dmc_pkg::req_t req_data,
	input  logic          q_full,
	output dmc_pkg::qctl_t qctl,
	output dmc_pkg::cmd_t cmd
);

	assign req_ready  = !q_full;
	assign qctl.push  = req_valid && !q_full;
	assign qctl.full  = q_full;

	always_comb begin
		cmd.op        = req_data.opcode ? dmc_pkg::OP_ACCESS : dmc_pkg::OP_LOAD;
		cmd.word      = req_data.address[dmc_pkg::WORD_W-1:0];
		cmd.line      = req_data.address[dmc_pkg::WORD_W +: dmc_pkg::LINE_W];
		cmd.tag       = req_data.address[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
		cmd.mem_addr  = req_data.address[dmc_pkg::MEM_AW-1:0];
		cmd.load_byte = req_data.load_byte;
	end

endmodule

// ===== design/dmc_queue.sv =====
// Short command queue between front end and back end.
module dmc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  dmc_pkg::qctl_t qctl,
	input  dmc_pkg::cmd_t  push_data,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output dmc_pkg::cmd_t  head
);

	dmc_pkg::cmd_t ent_q [dmc_pkg::QUEUE_DEPTH];
	logic [dmc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dmc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dmc_pkg::QPTR_W:0]   count_q;

	assign full  = count_q[dmc_pkg::QPTR_W];
	assign empty = (count_q == '0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qctl.push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (qctl.push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !qctl.push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (qctl.push)
			ent_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== design/dmc_back.sv =====
// Back end: tag lookup, line refill, backing memory and result register.
module dmc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [7:0]    cfg_data,
	input  logic          q_empty,
	input  dmc_pkg::cmd_t q_head,
	output logic          q_pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dmc_pkg::rsp_t rsp_data
);

	dmc_pkg::bk_state_t state_q, state_d;
	dmc_pkg::cmd_t      cur_q;
	logic [dmc_pkg::WORD_W:0]   fill_cnt_q;
	logic [dmc_pkg::WORD_W-1:0] fill_prev;
	logic [dmc_pkg::ADDR_W-1:0] fill_addr;
	logic               hit_q;
	logic [15:0]        miss_q;
	logic [31:0]        time_q;
	logic [32:0]        time_sum;
	logic [7:0]         pen_q;
	logic [dmc_pkg::TAG_W-1:0] tag_q [dmc_pkg::LINES];
	logic [dmc_pkg::LINES-1:0] valid_q;
	logic [7:0]         bm [dmc_pkg::MEMORY_BYTES];
	logic [7:0]         lm [dmc_pkg::LINES * dmc_pkg::LINE_BYTES];
	logic [7:0]         bm_rdata_q;
	logic [7:0]         lm_rdata_q;
	logic               rsp_valid_q;
	dmc_pkg::rsp_t      rsp_q;
	logic               lookup_hit;
	logic               fill_done;
	logic               rsp_free;
	logic               miss_now;

	assign lookup_hit = valid_q[cur_q.line] && (tag_q[cur_q.line] == cur_q.tag);
	assign fill_done  = fill_cnt_q[dmc_pkg::WORD_W];
	assign rsp_free   = !rsp_valid_q || rsp_ready;
	assign miss_now   = (state_q == dmc_pkg::BK_EXEC) && (cur_q.op == dmc_pkg::OP_ACCESS) &&
		!lookup_hit;
	assign fill_prev  = fill_cnt_q[dmc_pkg::WORD_W-1:0] - 1'b1;
	assign fill_addr  = {cur_q.tag, cur_q.line, fill_cnt_q[dmc_pkg::WORD_W-1:0]};
	assign time_sum   = {1'b0, time_q} + {25'b0, pen_q};

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			dmc_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = dmc_pkg::BK_EXEC;
				end
			end
			dmc_pkg::BK_EXEC: begin
				if (cur_q.op == dmc_pkg::OP_LOAD || lookup_hit)
					state_d = dmc_pkg::BK_RESP;
				else
					state_d = dmc_pkg::BK_FILL;
			end
			dmc_pkg::BK_FILL: begin
				if (fill_done)
					state_d = dmc_pkg::BK_READ;
			end
			dmc_pkg::BK_READ: begin
				state_d = dmc_pkg::BK_RESP;
			end
			dmc_pkg::BK_RESP: begin
				if (rsp_free) begin
					if (!q_empty) begin
						q_pop   = 1'b1;
						state_d = dmc_pkg::BK_EXEC;
					end else begin
						state_d = dmc_pkg::BK_IDLE;
					end
				end
			end
			default: state_d = dmc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmc_pkg::BK_IDLE;
			fill_cnt_q  <= '0;
			valid_q     <= '0;
			miss_q      <= '0;
			time_q      <= '0;
			pen_q       <= dmc_pkg::PENALTY_RESET;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			for (int i = 0; i < dmc_pkg::LINES; i++)
				tag_q[i] <= '1;
		end else begin
			state_q <= state_d;
			if (cfg_valid)
				pen_q <= cfg_data;
			if (miss_now) begin
				if (miss_q != '1)
					miss_q <= miss_q + 1'b1;
				time_q <= time_sum[32] ? '1 : time_sum[31:0];
				tag_q[cur_q.line]   <= cur_q.tag;
				valid_q[cur_q.line] <= 1'b1;
			end
			if (state_q == dmc_pkg::BK_FILL)
				fill_cnt_q <= fill_cnt_q + 1'b1;
			else
				fill_cnt_q <= '0;
			if (state_q == dmc_pkg::BK_RESP && rsp_free) begin
				rsp_valid_q         <= 1'b1;
				rsp_q.hit           <= hit_q;
				rsp_q.read_byte     <= (cur_q.op == dmc_pkg::OP_LOAD) ? cur_q.load_byte :
					lm_rdata_q;
				rsp_q.miss_total    <= miss_q;
				rsp_q.elapsed_time  <= time_q;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_head;
		if (state_q == dmc_pkg::BK_EXEC)
			hit_q <= (cur_q.op == dmc_pkg::OP_ACCESS) && lookup_hit;
	end

	always_ff @(posedge clk) begin
		if (state_q == dmc_pkg::BK_EXEC && cur_q.op == dmc_pkg::OP_LOAD)
			bm[cur_q.mem_addr] <= cur_q.load_byte;
		if (state_q == dmc_pkg::BK_FILL && !fill_done)
			bm_rdata_q <= bm[fill_addr[dmc_pkg::MEM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == dmc_pkg::BK_FILL && fill_cnt_q != '0)
			lm[{cur_q.line, fill_prev}] <= bm_rdata_q;
		if (state_q == dmc_pkg::BK_EXEC || state_q == dmc_pkg::BK_READ)
			lm_rdata_q <= lm[{cur_q.line, cur_q.word}];
	end

endmodule

// ===== design/direct_mapped_cache.sv =====
// Read-only direct-mapped cache of 8 lines of 16 bytes over a 4096-byte backing memory.
// Each request word either loads one backing memory byte or reads through the cache; each
// returns one response word with the byte, a hit flag and saturating miss and time counters.
// Requests enter a two-deep command queue and are accepted while it has room; the back end
// works one command at a time. A load or a hit goes through the back end's lookup and then its
// result register; a miss adds a refill that streams 16 bytes one per cycle through the backing
// memory's single read port with registered read data, then a line read, before the result register. The
// result register lets the next command start while a response waits. miss_penalty is
// written through the cfg channel, which is always ready; write it only while the block is idle.
module direct_mapped_cache (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dmc_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dmc_pkg::rsp_t rsp_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_data
);

	dmc_pkg::qctl_t qctl;
	dmc_pkg::cmd_t  cmd;
	dmc_pkg::cmd_t  q_head;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;

	assign cfg_ready = 1'b1;

	dmc_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.q_full    (q_full),
		.qctl      (qctl),
		.cmd       (cmd)
	);

	dmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.qctl      (qctl),
		.push_data (cmd),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	dmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

// ===== design/dmc_checker.sv =====
// Port-level checks on the cache response stream, bound to the top level.
module dmc_assertions (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input dmc_pkg::rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response word changed while stalled");

	a_miss_mono: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.miss_total >= $past(rsp_data.miss_total))
		else $error("miss count went backward");

	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.elapsed_time >= $past(rsp_data.elapsed_time))
		else $error("elapsed time went backward");

	a_hit_no_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.miss_total != $past(rsp_data.miss_total)) |-> !rsp_data.hit)
		else $error("hit reported with a new miss");

endmodule

bind direct_mapped_cache dmc_assertions u_dmc_assertions (.*);

// ===== dv/dmc_checker.sv =====
// Scoreboard for the direct-mapped cache: predicts every response word and compares it.
module dmc_checker
	import dmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  req_t       req_data,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  rsp_t       rsp_data,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output int         fails,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]       penalty;
	logic [TAG_W-1:0] line_tag [LINES];
	logic             line_filled [LINES];
	logic [7:0]       line_store [LINES*LINE_BYTES];
	logic [7:0]       mem_image [MEMORY_BYTES];
	logic [15:0]      misses;
	logic [31:0]      elapsed;
	rsp_t             expected_q [$];

	initial begin
		fails = 0;
		outstanding = 0;
	end

	function automatic rsp_t access_cache(req_t w);
		rsp_t              r;
		logic [WORD_W-1:0] wd;
		logic [LINE_W-1:0] ln;
		logic [TAG_W-1:0]  tg;
		logic [MEM_AW-1:0] base;
		wd = w.address[WORD_W-1:0];
		ln = w.address[WORD_W +: LINE_W];
		tg = w.address[ADDR_W-1 -: TAG_W];
		base = MEM_AW'(w.address & ~ADDR_W'(LINE_BYTES - 1));
		r = '0;
		if (w.opcode == OP_LOAD) begin
			mem_image[MEM_AW'(w.address)] = w.load_byte;
			r.read_byte = w.load_byte;
		end else begin
			if (line_filled[ln] && line_tag[ln] == tg) begin
				r.hit = 1'b1;
			end else begin
				if (misses != 16'hFFFF)
					misses = misses + 16'd1;
				if (elapsed > 32'hFFFF_FFFF - {24'd0, penalty})
					elapsed = 32'hFFFF_FFFF;
				else
					elapsed = elapsed + {24'd0, penalty};
				for (int i = 0; i < LINE_BYTES; i++)
					line_store[{ln, WORD_W'(i)}] = mem_image[base + MEM_AW'(i)];
				line_tag[ln] = tg;
				line_filled[ln] = 1'b1;
			end
			r.read_byte = line_store[{ln, wd}];
		end
		r.miss_total = misses;
		r.elapsed_time = elapsed;
		return r;
	endfunction

	function automatic void flag(string msg);
		fails++;
		if (fails <= 10)
			$display("%0t dmc_checker: %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			penalty = PENALTY_RESET;
			for (int i = 0; i < LINES; i++) begin
				line_tag[i] = '1;
				line_filled[i] = 1'b0;
			end
			for (int i = 0; i < LINES * LINE_BYTES; i++)
				line_store[i] = 8'h23;
			misses = '0;
			elapsed = '0;
			expected_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				penalty = cfg_data;
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					flag($sformatf("unexpected word hit=%0d byte=%02h misses=%0d time=%0d",
						rsp_data.hit, rsp_data.read_byte, rsp_data.miss_total,
						rsp_data.elapsed_time));
				end else begin
					want = expected_q.pop_front();
					if (rsp_data.hit !== want.hit)
						flag($sformatf("hit: expected %0d, got %0d", want.hit, rsp_data.hit));
					if (rsp_data.read_byte !== want.read_byte)
						flag($sformatf("read_byte: expected %02h, got %02h",
							want.read_byte, rsp_data.read_byte));
					if (rsp_data.miss_total !== want.miss_total)
						flag($sformatf("miss_total: expected %0d, got %0d",
							want.miss_total, rsp_data.miss_total));
					if (rsp_data.elapsed_time !== want.elapsed_time)
						flag($sformatf("elapsed_time: expected %0d, got %0d",
							want.elapsed_time, rsp_data.elapsed_time));
				end
			end
			if (req_valid && req_ready)
				expected_q.push_back(access_cache(req_data));
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the direct-mapped cache: stimulus, configuration phases and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dmc_pkg::*;

	localparam int BLOCKS      = MEMORY_BYTES / LINE_BYTES;
	localparam int CYCLE_LIMIT = 400000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req_data  = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = '0;
	logic       calm      = 1'b0;

	int          fails;
	int          outstanding;
	int          cycles = 0;
	int          items = 0;
	bit          written [MEMORY_BYTES];
	bit          listed [BLOCKS];
	int unsigned loaded [$];
	int unsigned last_block;

	always #10 clk = ~clk;

	direct_mapped_cache uut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req_data,
		.rsp_valid,
		.rsp_ready,
		.rsp_data,
		.cfg_valid,
		.cfg_ready,
		.cfg_data
	);

	dmc_checker u_check (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req_data,
		.rsp_valid,
		.rsp_ready,
		.rsp_data,
		.cfg_valid,
		.cfg_ready,
		.cfg_data,
		.fails,
		.outstanding
	);

	always @(posedge clk) begin
		rsp_ready <= calm || ($urandom_range(99) >= 13);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic void mark_written(logic [ADDR_W-1:0] a);
		int unsigned blk;
		bit          whole;
		written[a] = 1'b1;
		blk = a / LINE_BYTES;
		whole = 1'b1;
		for (int i = 0; i < LINE_BYTES; i++)
			whole &= written[blk * LINE_BYTES + i];
		if (whole && !listed[blk]) begin
			listed[blk] = 1'b1;
			loaded.push_back(blk);
		end
	endfunction

	task automatic send_word(req_t w);
		if (!calm) begin
			while ($urandom_range(99) < 13) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req_data <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (w.opcode == OP_LOAD)
			mark_written(w.address);
		items++;
	endtask

	task automatic store_byte(logic [ADDR_W-1:0] a, logic [7:0] v);
		req_t w;
		w.opcode = OP_LOAD;
		w.address = a;
		w.load_byte = v;
		send_word(w);
	endtask

	task automatic read_at(logic [ADDR_W-1:0] a);
		req_t w;
		w.opcode = OP_ACCESS;
		w.address = a;
		w.load_byte = 8'($urandom);
		send_word(w);
	endtask

	task automatic fill_block(int unsigned blk);
		for (int i = 0; i < LINE_BYTES; i++)
			store_byte(ADDR_W'(blk * LINE_BYTES + i), 8'($urandom));
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_penalty(logic [7:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_traffic(int count);
		int target;
		int pick;
		target = items + count;
		while (items < target) begin
			pick = $urandom_range(99);
			if (pick < 8 || loaded.size() == 0) begin
				fill_block($urandom_range(BLOCKS - 1));
			end else if (pick < 14) begin
				store_byte(ADDR_W'($urandom), 8'($urandom));
			end else begin
				if ($urandom_range(1))
					last_block = loaded[$urandom_range(loaded.size() - 1)];
				read_at(ADDR_W'(last_block * LINE_BYTES + $urandom_range(LINE_BYTES - 1)));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fill_block(0);
		fill_block(8);
		fill_block(BLOCKS - 1);
		store_byte(12'h000, 8'h00);
		store_byte(12'hFFF, 8'hFF);
		read_at(12'hFFF);
		read_at(12'hFF0);
		read_at(12'h000);
		read_at(12'h00F);
		store_byte(12'h003, 8'hA5);
		read_at(12'h003);
		read_at(12'h085);
		read_at(12'h003);
		read_at(12'h080);
		last_block = 0;

		set_penalty(8'hFF);
		run_traffic(330);
		calm <= 1'b1;
		set_penalty(8'h00);
		run_traffic(330);
		calm <= 1'b0;
		set_penalty(8'($urandom_range(254, 1)));
		run_traffic(330);

		settle();
		repeat (30) @(posedge clk);
		if (fails == 0 && outstanding == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
